// ===== src/pulse_period_tachometer_assert.svh =====
// Assertion macros shared by the tachometer modules.
`ifndef PULSE_PERIOD_TACHOMETER_ASSERT_SVH
`define PULSE_PERIOD_TACHOMETER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tachometer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tachometer assertion failed");

`endif

// ===== src/ppt_pkg.sv =====
// Package of widths, codes and control types for the pulse period tachometer.
package ppt_pkg;

   localparam int SIDE_W     = 2;
   localparam int NEWEST_W   = 15;
   localparam int ELAPSED_W  = 16;
   localparam int PULSES_W   = 16;
   localparam int FTIME_W    = 16;
   localparam int RPM_W      = 42;
   localparam int PERIOD_W   = 16;
   localparam int STATUS_W   = 3;
   localparam int WINDOW_W   = 15;
   localparam int SPOKES_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam int SCALE_W    = 26;
   localparam int PROD_W     = SPOKES_W + PERIOD_W;

   localparam int DIV_NUM_W  = RPM_W;
   localparam int DIV_DEN_W  = PROD_W;
   localparam int DIV_ITER_W = $clog2(DIV_NUM_W + 1);

   localparam logic [SCALE_W-1:0] RPM_SCALE = 26'd60000000;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 15'd50;
   localparam logic [SPOKES_W-1:0] SPOKES_RESET = 8'd1;

   localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_FLY   = 2'd2;
   localparam logic [SIDE_W-1:0] SIDE_BAD   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_SPOKES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLY_SPOKES   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SIDE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SUM_ZERO   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PERIOD_0   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FLY_TIME_0 = 3'd4;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
   localparam logic [OP_W-1:0] OP_WRITE   = 4'd2;
   localparam logic [OP_W-1:0] OP_READ    = 4'd3;
   localparam logic [OP_W-1:0] OP_ELAPSED = 4'd4;
   localparam logic [OP_W-1:0] OP_MEAN    = 4'd5;
   localparam logic [OP_W-1:0] OP_PMEAN   = 4'd6;
   localparam logic [OP_W-1:0] OP_DMUL    = 4'd7;
   localparam logic [OP_W-1:0] OP_DDIV    = 4'd8;
   localparam logic [OP_W-1:0] OP_FMUL    = 4'd9;
   localparam logic [OP_W-1:0] OP_FDIV    = 4'd10;
   localparam logic [OP_W-1:0] OP_RESULT  = 4'd11;

   localparam logic [DIV_ITER_W-1:0] RPM_ITERS = DIV_ITER_W'(SCALE_W);
   localparam logic [DIV_ITER_W-1:0] FLY_ITERS = DIV_ITER_W'(DIV_NUM_W);

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [STATUS_W-1:0] code;
   } dp_cmd_type;

   typedef struct packed {
      logic [SIDE_W-1:0] side;
      logic              ftime_zero;
      logic              walk_last;
      logic              sum_zero;
      logic              use_elapsed;
      logic              period_zero;
      logic              div_done;
   } dp_status_type;

endpackage

// ===== src/ppt_req_if.sv =====
// Query channel interface: one beat carries one tachometer query.
interface ppt_req_if import ppt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SIDE_W-1:0]    side;
   logic [NEWEST_W-1:0]  last_period;
   logic [ELAPSED_W-1:0] elapsed;
   logic [PULSES_W-1:0]  fly_pulses;
   logic [FTIME_W-1:0]   fly_time;

   modport source (output valid, side, last_period, elapsed, fly_pulses, fly_time,
                   input ready);
   modport sink (input valid, side, last_period, elapsed, fly_pulses, fly_time,
                 output ready);
endinterface

// ===== src/ppt_rsp_if.sv =====
// Result channel interface: one beat carries one speed result.
interface ppt_rsp_if import ppt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RPM_W-1:0]    rpm_milli;
   logic [PERIOD_W-1:0] period_used;
   logic [STATUS_W-1:0] status;

   modport source (output valid, rpm_milli, period_used, status, input ready);
   modport sink (input valid, rpm_milli, period_used, status, output ready);
endinterface

// ===== src/pulse_period_tachometer.sv =====
// Top level of the pulse period tachometer.
//
// Queries arrive as beats on req_ch; each names a side. A left or right drive
// query stores its newest period in that side's ring, averages the ring entries
// that lie within the window of it (or takes the elapsed time when that exceeds
// their sum plus the window) and returns rpm times 1000. A flywheel query
// returns rpm times 1000 from its pulse count and interval. Every query gives
// exactly one rsp_ch beat. Registers are written through csr_we, csr_index and
// csr_wdata; the user must write them only while idle, as the block itself does
// not enforce it. Queries are handled one at a time. In a drive query the ring
// walk reads one entry per cycle and the shared divider retires one quotient
// bit per cycle, first for the mean (when it is taken) and then for the speed.
// A flywheel query uses a single 42-bit division. The result waits in the output
// register while the receiver stalls; the next query is accepted meanwhile and
// its result is held back until that beat goes. Reset empties the rings, zeroes
// both ring pointers, restores the registers to their defaults and drops any
// pending result.
module pulse_period_tachometer import ppt_pkg::*; #(
   parameter int RING_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   ppt_req_if.sink               req_ch,
   ppt_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   ppt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ppt_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_side         (req_ch.side),
      .in_last_period  (req_ch.last_period),
      .in_elapsed      (req_ch.elapsed),
      .in_fly_pulses   (req_ch.fly_pulses),
      .in_fly_time     (req_ch.fly_time),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .out_rpm_milli   (rsp_ch.rpm_milli),
      .out_period_used (rsp_ch.period_used),
      .out_status      (rsp_ch.status)
   );

endmodule

// ===== src/ppt_divider.sv =====
// Restoring divider retiring one quotient bit per cycle.
module ppt_divider import ppt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_NUM_W-1:0]  num,
   input  logic [DIV_DEN_W-1:0]  den,
   input  logic [DIV_ITER_W-1:0] iters,
   output logic [DIV_NUM_W-1:0]  quo,
   output logic                  busy,
   output logic                  done
);

   logic [DIV_NUM_W-1:0]  quo_ff, quo_in;
   logic [DIV_DEN_W-1:0]  rem_ff, rem_in;
   logic [DIV_DEN_W-1:0]  den_ff, den_in;
   logic [DIV_ITER_W-1:0] left_ff, left_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_DEN_W:0]    trial;
   logic [DIV_DEN_W:0]    diff;
   logic                  fits;
   logic [DIV_ITER_W-1:0] shift;

   // The numerator is left-aligned so that only its significant bits are walked.
   assign shift = DIV_ITER_W'(DIV_NUM_W) - iters;
   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      left_in = left_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num << shift;
         rem_in  = '0;
         den_in  = den;
         left_in = iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in  = {quo_ff[DIV_NUM_W-2:0], fits};
         left_in = left_ff - DIV_ITER_W'(1);
         if (left_ff == DIV_ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      left_ff <= left_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo  = quo_ff;
   assign busy = busy_ff;
   assign done = done_ff;

endmodule

// ===== src/ppt_datapath.sv =====
// Datapath: registers, period rings, accumulator, multipliers and result registers.
`include "pulse_period_tachometer_assert.svh"

module ppt_datapath import ppt_pkg::*; #(
   parameter int RING_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [SIDE_W-1:0]     in_side,
   input  logic [NEWEST_W-1:0]   in_last_period,
   input  logic [ELAPSED_W-1:0]  in_elapsed,
   input  logic [PULSES_W-1:0]   in_fly_pulses,
   input  logic [FTIME_W-1:0]    in_fly_time,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [RPM_W-1:0]      out_rpm_milli,
   output logic [PERIOD_W-1:0]   out_period_used,
   output logic [STATUS_W-1:0]   out_status
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = NEWEST_W + $clog2(RING_DEPTH);
   localparam int CMP_W = SUM_W + 1;
   localparam int MEM_D = 2 ** (IDX_W + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

   // Item registers.
   logic [SIDE_W-1:0]    side_ff;
   logic [NEWEST_W-1:0]  newest_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [PULSES_W-1:0]  pulses_ff;
   logic [FTIME_W-1:0]   ftime_ff;

   // Configuration.
   logic [WINDOW_W-1:0] window_ff;
   logic [SPOKES_W-1:0] dspk_ff;
   logic [SPOKES_W-1:0] fspk_ff;
   logic [SPOKES_W-1:0] dspk_eff;
   logic [SPOKES_W-1:0] fspk_eff;

   // Rings: both sides share one store, the side selecting the upper half.
   logic [NEWEST_W-1:0] ring_mem [MEM_D];
   logic [MEM_D-1:0]    valid_ff;
   logic [IDX_W-1:0]    ptr_ff [2];
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W:0]      wr_addr;
   logic [IDX_W:0]      rd_addr;
   logic [NEWEST_W-1:0] rd_data_ff;
   logic                rd_valid_ff;
   logic                acc_pend_ff;

   // Accumulator and arithmetic.
   logic [SUM_W-1:0]     sum_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [NEWEST_W-1:0]  entry;
   logic [NEWEST_W-1:0]  spread;
   logic                 take;
   logic [PERIOD_W-1:0]  period_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [DIV_NUM_W-1:0] num_ff;

   logic [RPM_W-1:0]    rpm_ff;
   logic [PERIOD_W-1:0] per_ff;
   logic [STATUS_W-1:0] stat_ff;

   // Divider hookup.
   logic                  div_start;
   logic [DIV_NUM_W-1:0]  div_num;
   logic [DIV_DEN_W-1:0]  div_den;
   logic [DIV_ITER_W-1:0] div_iters;
   logic [DIV_NUM_W-1:0]  div_quo;
   logic                  div_busy;
   logic                  div_done;

   assign dspk_eff = (dspk_ff == '0) ? SPOKES_W'(1) : dspk_ff;
   assign fspk_eff = (fspk_ff == '0) ? SPOKES_W'(1) : fspk_ff;

   assign wr_addr = {side_ff[0], ptr_ff[side_ff[0]]};
   assign rd_addr = {side_ff[0], idx_ff};

   // An entry never written since reset reads as zero.
   assign entry  = rd_valid_ff ? rd_data_ff : '0;
   assign spread = (entry >= newest_ff) ? entry - newest_ff : newest_ff - entry;
   assign take   = spread <= window_ff;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         side_ff    <= in_side;
         newest_ff  <= in_last_period;
         elapsed_ff <= in_elapsed;
         pulses_ff  <= in_fly_pulses;
         ftime_ff   <= in_fly_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         dspk_ff   <= SPOKES_RESET;
         fspk_ff   <= SPOKES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW:       window_ff <= csr_wdata[WINDOW_W-1:0];
            CSR_DRIVE_SPOKES: dspk_ff   <= csr_wdata[SPOKES_W-1:0];
            CSR_FLY_SPOKES:   fspk_ff   <= csr_wdata[SPOKES_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE) begin
         ring_mem[wr_addr] <= newest_ff;
      end
      rd_data_ff <= ring_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         ptr_ff[0]   <= '0;
         ptr_ff[1]   <= '0;
         acc_pend_ff <= 1'b0;
      end else begin
         acc_pend_ff <= cmd.op == OP_READ;
         if (cmd.op == OP_WRITE) begin
            valid_ff[wr_addr] <= 1'b1;
            if (ptr_ff[side_ff[0]] == IDX_LAST) begin
               ptr_ff[side_ff[0]] <= '0;
            end else begin
               ptr_ff[side_ff[0]] <= ptr_ff[side_ff[0]] + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE) begin
         idx_ff   <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.op == OP_READ) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (acc_pend_ff && take) begin
            sum_ff   <= sum_ff + SUM_W'(entry);
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ELAPSED: period_ff <= elapsed_ff;
         OP_PMEAN:   period_ff <= div_quo[PERIOD_W-1:0];
         OP_DMUL:    prod_ff   <= PROD_W'(dspk_eff) * PROD_W'(period_ff);
         OP_FMUL: begin
            num_ff  <= DIV_NUM_W'(RPM_SCALE) * DIV_NUM_W'(pulses_ff);
            prod_ff <= PROD_W'(fspk_eff) * PROD_W'(ftime_ff);
         end
         OP_RESULT: begin
            stat_ff <= cmd.code;
            rpm_ff  <= (cmd.code == ST_OK) ? div_quo : '0;
            per_ff  <= (cmd.code == ST_OK && side_ff != SIDE_FLY) ? period_ff : '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = num_ff;
      div_den   = prod_ff;
      div_iters = FLY_ITERS;
      case (cmd.op)
         OP_MEAN: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(sum_ff);
            div_den   = DIV_DEN_W'(count_ff);
            div_iters = DIV_ITER_W'(SUM_W);
         end
         OP_DDIV: begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(RPM_SCALE);
            div_iters = RPM_ITERS;
         end
         OP_FDIV: begin
            div_start = 1'b1;
         end
         default: ;
      endcase
   end

   ppt_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .iters (div_iters),
      .quo   (div_quo),
      .busy  (div_busy),
      .done  (div_done)
   );

   assign status.side        = side_ff;
   assign status.ftime_zero  = ftime_ff == '0;
   assign status.walk_last   = idx_ff == IDX_LAST;
   assign status.sum_zero    = sum_ff == '0;
   assign status.use_elapsed = ({1'b0, sum_ff} + CMP_W'(window_ff)) < CMP_W'(elapsed_ff);
   assign status.period_zero = period_ff == '0;
   assign status.div_done    = div_done;

   assign out_rpm_milli   = rpm_ff;
   assign out_period_used = per_ff;
   assign out_status      = stat_ff;

   // Only drive sides ever touch the rings.
   `PPT_ASSERT_NOW(a_write_drive_side, clock, reset, cmd.op == OP_WRITE, !side_ff[1])
   // The newest period always matches itself, so a mean never divides by zero.
   `PPT_ASSERT_NOW(a_mean_count, clock, reset, cmd.op == OP_MEAN, count_ff != '0)
   `PPT_ASSERT_NOW(a_div_idle, clock, reset, div_start, !div_busy)

endmodule

// ===== src/ppt_controller.sv =====
// Controller: sequences each query through the datapath and owns the handshakes.
`include "pulse_period_tachometer_assert.svh"

module ppt_controller import ppt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
   localparam logic [ST_W-1:0] S_DECODE = 4'd1;
   localparam logic [ST_W-1:0] S_WALK   = 4'd2;
   localparam logic [ST_W-1:0] S_DRAIN  = 4'd3;
   localparam logic [ST_W-1:0] S_CHECK  = 4'd4;
   localparam logic [ST_W-1:0] S_MWAIT  = 4'd5;
   localparam logic [ST_W-1:0] S_PCHK   = 4'd6;
   localparam logic [ST_W-1:0] S_DDIV   = 4'd7;
   localparam logic [ST_W-1:0] S_FDIV   = 4'd8;
   localparam logic [ST_W-1:0] S_DWAIT  = 4'd9;
   localparam logic [ST_W-1:0] S_OUT    = 4'd10;

   logic [ST_W-1:0]     state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd.op   = OP_NONE;
      cmd.code = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.side == SIDE_BAD) begin
               code_in  = ST_BAD_SIDE;
               state_in = S_OUT;
            end else if (status.side == SIDE_FLY) begin
               if (status.ftime_zero) begin
                  code_in  = ST_FLY_TIME_0;
                  state_in = S_OUT;
               end else begin
                  cmd.op   = OP_FMUL;
                  state_in = S_FDIV;
               end
            end else begin
               cmd.op   = OP_WRITE;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.op = OP_READ;
            if (status.walk_last) begin
               state_in = S_DRAIN;
            end
         end
         // The last entry read is summed during this cycle.
         S_DRAIN: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.sum_zero) begin
               code_in  = ST_SUM_ZERO;
               state_in = S_OUT;
            end else if (status.use_elapsed) begin
               cmd.op   = OP_ELAPSED;
               state_in = S_PCHK;
            end else begin
               cmd.op   = OP_MEAN;
               state_in = S_MWAIT;
            end
         end
         S_MWAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_PMEAN;
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (status.period_zero) begin
               code_in  = ST_PERIOD_0;
               state_in = S_OUT;
            end else begin
               cmd.op   = OP_DMUL;
               state_in = S_DDIV;
            end
         end
         S_DDIV: begin
            cmd.op   = OP_DDIV;
            state_in = S_DWAIT;
         end
         S_FDIV: begin
            cmd.op   = OP_FDIV;
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (status.div_done) begin
               code_in  = ST_OK;
               state_in = S_OUT;
            end
         end
         // The result registers are the output payload, so wait for them to drain.
         S_OUT: begin
            if (slot_free) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.op == OP_RESULT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         code_ff      <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `PPT_ASSERT_NOW(a_result_slot_free, clock, reset, cmd.op == OP_RESULT, slot_free)
   `PPT_ASSERT_NEXT(a_result_shown, clock, reset, cmd.op == OP_RESULT, rsp_valid_ff)
   `PPT_ASSERT_NEXT(a_accept_decodes, clock, reset, req_valid && req_ready,
                    state_ff == S_DECODE)

endmodule
